// File: hdl/cra_pkg.sv
`default_nettype none

package cra_pkg;

    // Field widths of the request and result items
    localparam int FUNC_W  = 2;
    localparam int ELEM_W  = 17;
    localparam int CNT_W   = 6;
    localparam int FIRST_W = 6;
    localparam int LIMIT_W = 7;
    localparam int FROW_W  = 6;
    localparam int ROW_W   = 5;

    // Internal widths: span counter holds up to 65, accumulator below 2^18
    localparam int SPAN_W  = 7;
    localparam int ACC_W   = 18;
    localparam int CMP_W   = 8;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MULTI = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SEARCH,
        ST_COMMIT,
        ST_NOSPACE,
        ST_FREE_RD,
        ST_FREE_WR
    } state_t;

    typedef struct packed {
        logic [FIRST_W-1:0] span_first;
        logic [LIMIT_W-1:0] span_limit;
        logic [ROW_W-1:0]   granted_row;
        logic               out_of_memory;
        logic               last_of_run;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/cra_occ_mem.sv
`default_nettype none

module cra_occ_mem #(
    parameter int ROWS = 32,
    parameter int CROSSBARS = 64,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [RW-1:0]        rd_addr,
    output logic [CROSSBARS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [RW-1:0]        wr_addr,
    input  logic [CROSSBARS-1:0] wr_data
);

    logic [CROSSBARS-1:0] mem [ROWS];
    logic [ROWS-1:0]      row_valid_reg;
    logic [CROSSBARS-1:0] rd_data_reg;
    logic                 rd_live_reg;

    // Write the occupancy row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; forward a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    // Track rows written since reset; unwritten rows read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= row_valid_reg[rd_addr] || (wr_en && (wr_addr == rd_addr));
            end
        end
    end

    assign rd_data = rd_live_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: hdl/cra_out_stage.sv
`default_nettype none

module cra_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_valid,
    input  cra_pkg::res_t                res,
    output logic                         slot_free,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cra_pkg::FIRST_W-1:0]  span_first,
    output logic [cra_pkg::LIMIT_W-1:0]  span_limit,
    output logic [cra_pkg::ROW_W-1:0]    granted_row,
    output logic                         out_of_memory,
    output logic                         last_of_run
);

    import cra_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    // Load a new item when the slot empties, drop a taken one
    always_comb
    begin
        if (res_valid && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign span_first    = res_reg.span_first;
    assign span_limit    = res_reg.span_limit;
    assign granted_row   = res_reg.granted_row;
    assign out_of_memory = res_reg.out_of_memory;
    assign last_of_run   = res_reg.last_of_run;

endmodule

`default_nettype wire

// File: hdl/cra_engine.sv
`default_nettype none

module cra_engine #(
    parameter int ROWS = 32,
    parameter int CROSSBARS = 64,
    parameter int HEIGHT = 1024,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cra_pkg::FUNC_W-1:0]          func,
    input  logic [cra_pkg::ELEM_W-1:0]          elem_count,
    input  logic [cra_pkg::CNT_W-1:0]           row_count,
    input  logic [cra_pkg::FIRST_W-1:0]         free_first,
    input  logic [cra_pkg::LIMIT_W-1:0]         free_limit,
    input  logic signed [cra_pkg::FROW_W-1:0]   free_row,
    output logic                                mem_rd_en,
    output logic [RW-1:0]                       mem_rd_addr,
    input  logic [CROSSBARS-1:0]                mem_rd_data,
    output logic                                mem_wr_en,
    output logic [RW-1:0]                       mem_wr_addr,
    output logic [CROSSBARS-1:0]                mem_wr_data,
    output logic                                res_valid,
    output cra_pkg::res_t                       res,
    input  logic                                slot_free
);

    import cra_pkg::*;

    localparam int RCW = $clog2(ROWS + 1);
    localparam int CBW = $clog2(CROSSBARS);

    state_t              state_reg, state_next;
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic [CNT_W-1:0]    want_reg, want_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CBW-1:0]      s_reg, s_next;
    logic [CBW-1:0]      i_reg, i_next;
    logic [CBW-1:0]      next_start_reg, next_start_next;
    logic [RCW-1:0]      rd_row_reg, rd_row_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [RW-1:0]       chk_row_reg, chk_row_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FIRST_W-1:0]  ff_reg, ff_next;
    logic [LIMIT_W-1:0]  flc_reg, flc_next;
    logic [RW-1:0]       fr_reg, fr_next;

    logic                 accept;
    logic [ELEM_W-1:0]    elem_eff;
    logic [LIMIT_W-1:0]   flc_in;
    logic                 free_ok;
    logic                 span_done;
    logic                 span_big;
    logic                 want_big;
    logic                 s_over;
    logic                 hit;
    logic                 reach;
    logic                 found;
    logic                 row_end;
    logic                 start_end;
    logic                 last_start;
    logic                 issue;
    logic [CROSSBARS-1:0] alloc_mask;
    logic [CROSSBARS-1:0] free_mask;

    // Decode the incoming request
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign elem_eff = (elem_count == '0) ? ELEM_W'(1) : elem_count;
    assign flc_in   = (free_limit > LIMIT_W'(CROSSBARS)) ? LIMIT_W'(CROSSBARS) : free_limit;
    assign free_ok  = !free_row[FROW_W-1]
                      && (CMP_W'(free_row[FROW_W-2:0]) < CMP_W'(ROWS))
                      && (CMP_W'(free_first) < CMP_W'(flc_in));

    // Span sizing and search conditions
    assign span_done  = acc_reg >= ACC_W'(elem_reg);
    assign span_big   = span_reg > SPAN_W'(CROSSBARS);
    assign want_big   = CMP_W'(want_reg) > CMP_W'(ROWS);
    assign s_over     = (CMP_W'(s_reg) + CMP_W'(span_reg)) > CMP_W'(CROSSBARS);
    assign hit        = (mem_rd_data & alloc_mask) == '0;
    assign reach      = (CMP_W'(cnt_reg) + CMP_W'(1)) == CMP_W'(want_reg);
    assign found      = chk_valid_reg && hit && reach;
    assign row_end    = chk_valid_reg && (chk_row_reg == RW'(ROWS - 1));
    assign start_end  = s_over || (row_end && !found);
    assign last_start = i_reg == CBW'(CROSSBARS - 1);
    assign issue      = rd_row_reg < RCW'(ROWS);

    // Build the crossbar masks of the current span and of the free span
    always_comb
    begin
        for (int b = 0; b < CROSSBARS; b++)
        begin
            alloc_mask[b] = (CMP_W'(b) >= CMP_W'(s_reg))
                            && (CMP_W'(b) < (CMP_W'(s_reg) + CMP_W'(span_reg)));
            free_mask[b]  = (CMP_W'(b) >= CMP_W'(ff_reg))
                            && (CMP_W'(b) < CMP_W'(flc_reg));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_ALLOC)
                    begin
                        state_next = ST_SPAN;
                    end
                    else if ((func == FUNC_MULTI) && (row_count != '0))
                    begin
                        state_next = ST_SPAN;
                    end
                    else if ((func == FUNC_FREE) && free_ok)
                    begin
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_SPAN:
            begin
                if (span_done)
                begin
                    state_next = (want_big || span_big) ? ST_NOSPACE : ST_SEARCH;
                end
                else if (span_big)
                begin
                    state_next = ST_NOSPACE;
                end
            end
            ST_SEARCH:
            begin
                if (start_end)
                begin
                    if (last_start)
                    begin
                        state_next = ST_NOSPACE;
                    end
                end
                else if (found)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (chk_valid_reg && hit && slot_free && reach)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NOSPACE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory requests, handshake and result items
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        res_valid   = 1'b0;
        res         = '0;
        case (state_reg)
            ST_SEARCH:
            begin
                mem_rd_en   = issue && !s_over;
                mem_rd_addr = rd_row_reg[RW-1:0];
            end
            ST_COMMIT:
            begin
                mem_rd_en   = !chk_valid_reg;
                mem_rd_addr = rd_row_reg[RW-1:0];
                if (chk_valid_reg && hit && slot_free)
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = chk_row_reg;
                    mem_wr_data     = mem_rd_data | alloc_mask;
                    res_valid       = 1'b1;
                    res.span_first  = FIRST_W'(s_reg);
                    res.span_limit  = LIMIT_W'(s_reg) + LIMIT_W'(span_reg);
                    res.granted_row = ROW_W'(chk_row_reg);
                    res.last_of_run = reach;
                end
            end
            ST_NOSPACE:
            begin
                res_valid         = slot_free;
                res.out_of_memory = 1'b1;
                res.last_of_run   = 1'b1;
            end
            ST_FREE_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = fr_reg;
            end
            ST_FREE_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = fr_reg;
                mem_wr_data = mem_rd_data & ~free_mask;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        elem_next       = elem_reg;
        want_next       = want_reg;
        span_next       = span_reg;
        acc_next        = acc_reg;
        s_next          = s_reg;
        i_next          = i_reg;
        next_start_next = next_start_reg;
        rd_row_next     = rd_row_reg;
        chk_valid_next  = chk_valid_reg;
        chk_row_next    = chk_row_reg;
        cnt_next        = cnt_reg;
        ff_next         = ff_reg;
        flc_next        = flc_reg;
        fr_next         = fr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    elem_next      = elem_eff;
                    want_next      = (func == FUNC_ALLOC) ? CNT_W'(1) : row_count;
                    span_next      = SPAN_W'(1);
                    acc_next       = ACC_W'(HEIGHT);
                    s_next         = next_start_reg;
                    i_next         = '0;
                    rd_row_next    = '0;
                    chk_valid_next = 1'b0;
                    cnt_next       = '0;
                    ff_next        = free_first;
                    flc_next       = flc_in;
                    fr_next        = RW'(free_row[FROW_W-2:0]);
                end
            end
            ST_SPAN:
            begin
                // Grow the span one crossbar height a cycle
                if (!span_done && !span_big)
                begin
                    span_next = span_reg + SPAN_W'(1);
                    acc_next  = acc_reg + ACC_W'(HEIGHT);
                end
            end
            ST_SEARCH:
            begin
                if (start_end)
                begin
                    // Advance to the next start position, wrapping
                    i_next         = i_reg + CBW'(1);
                    s_next         = (s_reg == CBW'(CROSSBARS - 1)) ? '0 : s_reg + CBW'(1);
                    rd_row_next    = '0;
                    chk_valid_next = 1'b0;
                    cnt_next       = '0;
                end
                else if (found)
                begin
                    rd_row_next    = '0;
                    chk_valid_next = 1'b0;
                    cnt_next       = '0;
                end
                else
                begin
                    // Stream row reads, count free rows as data returns
                    chk_valid_next = issue;
                    if (issue)
                    begin
                        chk_row_next = rd_row_reg[RW-1:0];
                        rd_row_next  = rd_row_reg + RCW'(1);
                    end
                    if (chk_valid_reg && hit)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_COMMIT:
            begin
                if (!chk_valid_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_row_next   = rd_row_reg[RW-1:0];
                    rd_row_next    = rd_row_reg + RCW'(1);
                end
                else if (hit)
                begin
                    // Mark one row per delivered item; hold while the slot is busy
                    if (slot_free)
                    begin
                        cnt_next       = cnt_reg + CNT_W'(1);
                        chk_valid_next = 1'b0;
                        if (reach)
                        begin
                            next_start_next = s_reg;
                        end
                    end
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            default:
            begin
                chk_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chk_valid_reg  <= 1'b0;
            next_start_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_valid_reg  <= chk_valid_next;
            next_start_reg <= next_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg    <= elem_next;
        want_reg    <= want_next;
        span_reg    <= span_next;
        acc_reg     <= acc_next;
        s_reg       <= s_next;
        i_reg       <= i_next;
        rd_row_reg  <= rd_row_next;
        chk_row_reg <= chk_row_next;
        cnt_reg     <= cnt_next;
        ff_reg      <= ff_next;
        flc_reg     <= flc_next;
        fr_reg      <= fr_next;
    end

endmodule

`default_nettype wire

// File: hdl/crossbar_register_allocator_top.sv
// Next-fit crossbar register allocator.
// Input channel (in_valid / in_stall) takes one request item: allocate one
// row, allocate several rows, or free a row over a span of crossbars. The
// output channel (out_valid / out_stall) delivers one result item per granted
// row, or a single item with out_of_memory set; last_of_run closes each run.
// A free gives no result item.
// One request is worked at a time; in_stall is high until it is finished.
// Span sizing grows the span by one crossbar at a time. The search then tries
// each start position in turn, streaming one occupancy row per cycle from the
// row memory. Marking scans the rows again from the first, reading each one
// and writing back each free row as it is granted. A free reads its row and
// writes it back with the span cleared.
// Reset empties the occupancy memory at once (per-row valid bits) and sets
// the search pointer to crossbar zero; there is no clearing pass.
// While the receiver stalls, the waiting result item holds in the output
// register and marking pauses until the slot frees.
`default_nettype none

module crossbar_register_allocator_top #(
    parameter int ROWS = 32,
    parameter int CROSSBARS = 64,
    parameter int HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cra_pkg::FUNC_W-1:0]          func,
    input  logic [cra_pkg::ELEM_W-1:0]          elem_count,
    input  logic [cra_pkg::CNT_W-1:0]           row_count,
    input  logic [cra_pkg::FIRST_W-1:0]         free_first,
    input  logic [cra_pkg::LIMIT_W-1:0]         free_limit,
    input  logic signed [cra_pkg::FROW_W-1:0]   free_row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cra_pkg::FIRST_W-1:0]         span_first,
    output logic [cra_pkg::LIMIT_W-1:0]         span_limit,
    output logic [cra_pkg::ROW_W-1:0]           granted_row,
    output logic                                out_of_memory,
    output logic                                last_of_run
);

    import cra_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                 mem_rd_en;
    logic [RW-1:0]        mem_rd_addr;
    logic [CROSSBARS-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [RW-1:0]        mem_wr_addr;
    logic [CROSSBARS-1:0] mem_wr_data;
    logic                 res_valid;
    res_t                 res;
    logic                 slot_free;

    cra_engine #(
        .ROWS      (ROWS),
        .CROSSBARS (CROSSBARS),
        .HEIGHT    (HEIGHT)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .elem_count  (elem_count),
        .row_count   (row_count),
        .free_first  (free_first),
        .free_limit  (free_limit),
        .free_row    (free_row),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .res_valid   (res_valid),
        .res         (res),
        .slot_free   (slot_free)
    );

    cra_occ_mem #(
        .ROWS      (ROWS),
        .CROSSBARS (CROSSBARS)
    ) u_occ_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    cra_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .slot_free     (slot_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .span_first    (span_first),
        .span_limit    (span_limit),
        .granted_row   (granted_row),
        .out_of_memory (out_of_memory),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
